// ===== rtl/tmeu_pkg.sv =====
// ============================================================================
// Tape machine execute unit package
// Shared types, opcode codes and default sizes for the execute unit.
// ============================================================================
package tmeu_pkg;

    localparam int TAPE_CELLS_DEF = 32768;
    localparam int CELL_BITS_DEF  = 8;
    localparam int MAX_RUN_DEF    = 255;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [2:0] {
        OP_RIGHT = 3'd0,
        OP_LEFT  = 3'd1,
        OP_ADD   = 3'd2,
        OP_SUB   = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_JZ    = 3'd6,
        OP_JNZ   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } back_state_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         repeat_count;
        logic signed [15:0] jump_offset;
        logic [7:0]         in_byte;
        logic               in_eof;
    } request_t;

    typedef struct packed {
        logic               out_valid;
        logic [7:0]         out_byte;
        logic               branch_taken;
        logic signed [15:0] program_step;
        logic               head_fault;
    } result_t;

    // Decoded instruction as it waits in the queue.
    typedef struct packed {
        op_t                op;
        logic [7:0]         count;
        logic signed [15:0] jump_offset;
        logic [7:0]         in_byte;
        logic               in_eof;
    } cmd_t;

endpackage

// ===== rtl/tmeu_front.sv =====
// ============================================================================
// Tape machine execute unit front end
// Accepts instructions, decodes the opcode, clamps the run length and pushes
// the decoded command into the queue.
// ============================================================================
module tmeu_front #(
    parameter int MAX_RUN = tmeu_pkg::MAX_RUN_DEF
) (
    input  logic              start,
    output logic              busy,
    input  tmeu_pkg::request_t request,
    input  logic              queue_full,
    input  logic              clearing,
    output logic              push,
    output tmeu_pkg::cmd_t    push_data
);

    logic [7:0] count_sat;

    assign busy = queue_full || clearing;
    assign push = start && !busy;

    always_comb
    begin
        if (32'(request.repeat_count) > 32'(MAX_RUN))
            count_sat = 8'(MAX_RUN);
        else
            count_sat = request.repeat_count;
    end

    always_comb
    begin
        push_data.op          = tmeu_pkg::op_t'(request.mode);
        push_data.count       = count_sat;
        push_data.jump_offset = request.jump_offset;
        push_data.in_byte     = request.in_byte;
        push_data.in_eof      = request.in_eof;
    end

endmodule

// ===== rtl/tmeu_queue.sv =====
// ============================================================================
// Tape machine execute unit command queue
// Short first-in first-out buffer between the front end and the back end.
// ============================================================================
module tmeu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tmeu_pkg::cmd_t push_data,
    input  logic           pop,
    output tmeu_pkg::cmd_t pop_data,
    output logic           empty,
    output logic           full
);

    tmeu_pkg::cmd_t                         entry_reg [tmeu_pkg::QUEUE_DEPTH];
    logic [tmeu_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [tmeu_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [tmeu_pkg::QUEUE_CNT_W-1:0]       cnt_reg, cnt_next;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == tmeu_pkg::QUEUE_CNT_W'(tmeu_pkg::QUEUE_DEPTH));
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tmeu_pkg::QUEUE_PTR_W'(tmeu_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tmeu_pkg::QUEUE_PTR_W'(tmeu_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/tmeu_back.sv =====
// ============================================================================
// Tape machine execute unit back end
// Owns the tape memory and the head; clears the tape after reset, then
// executes one queued command per read and read-modify-write pass.
// ============================================================================
module tmeu_back #(
    parameter int TAPE_CELLS = tmeu_pkg::TAPE_CELLS_DEF,
    parameter int CELL_BITS  = tmeu_pkg::CELL_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  tmeu_pkg::cmd_t    cmd,
    output logic              pop,
    output logic              clearing,
    output logic              done,
    output tmeu_pkg::result_t result
);

    localparam int HEAD_W = $clog2(TAPE_CELLS);
    localparam int SUM_W  = ((HEAD_W > 8) ? HEAD_W : 8) + 1;

    logic [CELL_BITS-1:0]   tape_mem [TAPE_CELLS];
    logic [CELL_BITS-1:0]   rd_data_reg;

    tmeu_pkg::back_state_t  state_reg, state_next;
    logic [HEAD_W-1:0]      head_reg, head_next;
    logic [HEAD_W-1:0]      clr_reg, clr_next;
    tmeu_pkg::cmd_t         cmd_reg;
    logic                   done_reg, done_next;
    tmeu_pkg::result_t      result_reg, result_next;

    logic                   mem_we;
    logic [HEAD_W-1:0]      mem_waddr;
    logic [CELL_BITS-1:0]   mem_wdata;

    logic [SUM_W-1:0]       head_ext, count_ext, right_sum, left_diff;
    logic [CELL_BITS-1:0]   cur_cell;
    logic                   clr_last;

    assign cur_cell  = rd_data_reg;
    assign head_ext  = SUM_W'(head_reg);
    assign count_ext = SUM_W'(cmd_reg.count);
    assign right_sum = head_ext + count_ext;
    assign left_diff = head_ext - count_ext;
    assign clr_last  = (clr_reg == HEAD_W'(TAPE_CELLS - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmeu_pkg::ST_CLEAR:
            begin
                if (clr_last)
                    state_next = tmeu_pkg::ST_IDLE;
            end
            tmeu_pkg::ST_IDLE:
            begin
                if (!queue_empty)
                    state_next = tmeu_pkg::ST_EXEC;
            end
            tmeu_pkg::ST_EXEC:
                state_next = tmeu_pkg::ST_IDLE;
            default:
                state_next = tmeu_pkg::ST_CLEAR;
        endcase
    end

    // Datapath and control outputs.
    always_comb
    begin
        pop         = 1'b0;
        clearing    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = head_reg;
        mem_wdata   = '0;
        head_next   = head_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            tmeu_pkg::ST_CLEAR:
            begin
                clearing  = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            tmeu_pkg::ST_IDLE:
            begin
                pop = !queue_empty;
            end
            tmeu_pkg::ST_EXEC:
            begin
                done_next                = 1'b1;
                result_next.out_valid    = 1'b0;
                result_next.out_byte     = '0;
                result_next.branch_taken = 1'b0;
                result_next.program_step = 16'sd1;
                result_next.head_fault   = 1'b0;
                unique case (cmd_reg.op)
                    tmeu_pkg::OP_RIGHT:
                    begin
                        if (right_sum >= SUM_W'(TAPE_CELLS))
                            result_next.head_fault = 1'b1;
                        else
                            head_next = right_sum[HEAD_W-1:0];
                    end
                    tmeu_pkg::OP_LEFT:
                    begin
                        if (count_ext > head_ext)
                            result_next.head_fault = 1'b1;
                        else
                            head_next = left_diff[HEAD_W-1:0];
                    end
                    tmeu_pkg::OP_ADD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = cur_cell + CELL_BITS'(cmd_reg.count);
                    end
                    tmeu_pkg::OP_SUB:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = cur_cell - CELL_BITS'(cmd_reg.count);
                    end
                    tmeu_pkg::OP_OUT:
                    begin
                        result_next.out_valid = 1'b1;
                        result_next.out_byte  = cur_cell[7:0];
                    end
                    tmeu_pkg::OP_IN:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = cmd_reg.in_eof ? '1 : CELL_BITS'(cmd_reg.in_byte);
                    end
                    tmeu_pkg::OP_JZ:
                    begin
                        if (cur_cell == '0)
                        begin
                            result_next.branch_taken = 1'b1;
                            result_next.program_step = cmd_reg.jump_offset;
                        end
                    end
                    tmeu_pkg::OP_JNZ:
                    begin
                        if (cur_cell != '0)
                        begin
                            result_next.branch_taken = 1'b1;
                            result_next.program_step = cmd_reg.jump_offset;
                        end
                    end
                    default:
                    begin
                        result_next.head_fault = 1'b0;
                    end
                endcase
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmeu_pkg::ST_CLEAR;
            head_reg  <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (pop)
            cmd_reg <= cmd;
    end

    // The cell under the head is read while the command is popped, and
    // written back in the following cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tape_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= tape_mem[head_reg];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/tape_machine_execute_unit.sv =====
// ============================================================================
// Tape machine execute unit
// Executes run-length instructions of a tape machine against a tape memory.
// ============================================================================
// Flow: a taken start writes the command into the queue; the back end pops it
// in its idle state while reading the cell under the head, executes it in the
// exec state and registers the result onto done. The back end finishes one
// instruction before it pops the next; meanwhile the queue holds up to two.
// Reset: head goes to zero and the tape is cleared one cell per cycle;
// busy stays high until the whole tape is cleared.
// Results are strobed on done for one cycle; the receiver cannot stall.
module tape_machine_execute_unit #(
    parameter int TAPE_CELLS = tmeu_pkg::TAPE_CELLS_DEF,
    parameter int CELL_BITS  = tmeu_pkg::CELL_BITS_DEF,
    parameter int MAX_RUN    = tmeu_pkg::MAX_RUN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tmeu_pkg::request_t request,
    output logic               done,
    output tmeu_pkg::result_t  result
);

    tmeu_pkg::cmd_t push_data;
    tmeu_pkg::cmd_t pop_data;
    logic           push;
    logic           pop;
    logic           queue_empty;
    logic           queue_full;
    logic           clearing;

    tmeu_front #(
        .MAX_RUN    (MAX_RUN)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .request    (request),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .push_data  (push_data)
    );

    tmeu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .pop_data   (pop_data),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    tmeu_back #(
        .TAPE_CELLS (TAPE_CELLS),
        .CELL_BITS  (CELL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .cmd         (pop_data),
        .pop         (pop),
        .clearing    (clearing),
        .done        (done),
        .result      (result)
    );

endmodule

// ===== rtl/tmeu_checker.sv =====
// ============================================================================
// Tape machine execute unit checker
// Port-level properties of the execute unit, bound to the top level.
// ============================================================================
module tmeu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               done,
    input tmeu_pkg::result_t  result
);

    // During reset the tape is being cleared, so no request may be taken.
    a_busy_in_reset: assert property (@(posedge clk) !rst_n |-> busy)
        else $error("busy low while in reset");

    a_no_done_in_reset: assert property (@(posedge clk) !rst_n |=> !done)
        else $error("done high while in reset");

    // The back end returns to idle after every command, so strobes never touch.
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobed in two consecutive cycles");

    // At most one of output, branch and fault per result.
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((32'(result.out_valid) + 32'(result.branch_taken)
                   + 32'(result.head_fault)) <= 32'd1))
        else $error("result flags not mutually exclusive");

    a_step_untaken: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.branch_taken) |-> (result.program_step == 16'sd1))
        else $error("program step not one on an untaken branch");

endmodule

bind tape_machine_execute_unit tmeu_checker u_tmeu_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

// ===== verif/tape_machine_execute_unit_tb.sv =====
// ============================================================================
// Tape machine execute unit testbench
// Sends instruction requests through the start/busy handshake in random
// bursts, keeps a shadow tape and head to predict every result, and checks
// each strobed result field by field against the oldest prediction. A short
// directed program covers the edge cases first, then random programs follow,
// including one walk out to the right end of the tape and back.
// ============================================================================
module tape_machine_execute_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPE_CELLS  = tmeu_pkg::TAPE_CELLS_DEF;
    localparam int CELL_BITS   = tmeu_pkg::CELL_BITS_DEF;
    localparam int MAX_RUN     = tmeu_pkg::MAX_RUN_DEF;
    localparam int N_RANDOM    = 1150;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    tmeu_pkg::request_t  request = '0;
    logic                busy;
    logic                done;
    tmeu_pkg::result_t   result;

    // Shadow state of the tape and head, advanced as each request is taken.
    logic [CELL_BITS-1:0] model_tape [TAPE_CELLS];
    int unsigned          model_head;

    // Head position as the program generator sees it; moves depend on
    // nothing but the instruction stream, so it can be tracked up front.
    int unsigned          gen_head;

    tmeu_pkg::request_t program_queue[$];
    tmeu_pkg::result_t  outcome_queue[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned n_total        = 0;
    int unsigned n_results      = 0;
    int          burst_left     = 0;
    int          gap_left       = 0;

    tape_machine_execute_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    function automatic tmeu_pkg::result_t run_instruction(tmeu_pkg::request_t r);
        tmeu_pkg::result_t    res;
        int unsigned          count;
        logic [CELL_BITS-1:0] cur_val;
        res = '0;
        res.program_step = 16'sd1;
        count = 32'(r.repeat_count);
        if (count > MAX_RUN)
            count = MAX_RUN;
        cur_val = model_tape[model_head];
        case (tmeu_pkg::op_t'(r.mode))
            tmeu_pkg::OP_RIGHT:
            begin
                if (model_head + count >= TAPE_CELLS)
                    res.head_fault = 1'b1;
                else
                    model_head = model_head + count;
            end
            tmeu_pkg::OP_LEFT:
            begin
                if (count > model_head)
                    res.head_fault = 1'b1;
                else
                    model_head = model_head - count;
            end
            tmeu_pkg::OP_ADD:
                model_tape[model_head] = cur_val + CELL_BITS'(count);
            tmeu_pkg::OP_SUB:
                model_tape[model_head] = cur_val - CELL_BITS'(count);
            tmeu_pkg::OP_OUT:
            begin
                res.out_valid = 1'b1;
                res.out_byte  = cur_val[7:0];
            end
            tmeu_pkg::OP_IN:
                model_tape[model_head] = r.in_eof ? '1 : CELL_BITS'(r.in_byte);
            tmeu_pkg::OP_JZ:
            begin
                if (cur_val == '0)
                begin
                    res.branch_taken = 1'b1;
                    res.program_step = r.jump_offset;
                end
            end
            default:
            begin
                if (cur_val != '0)
                begin
                    res.branch_taken = 1'b1;
                    res.program_step = r.jump_offset;
                end
            end
        endcase
        return res;
    endfunction

    function automatic void queue_instr(tmeu_pkg::op_t op, int unsigned count,
                                        logic [15:0] offset, logic [7:0] in_byte,
                                        logic in_eof);
        tmeu_pkg::request_t r;
        r.mode         = op;
        r.repeat_count = count[7:0];
        r.jump_offset  = offset;
        r.in_byte      = in_byte;
        r.in_eof       = in_eof;
        program_queue.push_back(r);
        if (op == tmeu_pkg::OP_RIGHT && gen_head + r.repeat_count < TAPE_CELLS)
            gen_head = gen_head + r.repeat_count;
        else if (op == tmeu_pkg::OP_LEFT && r.repeat_count <= gen_head)
            gen_head = gen_head - r.repeat_count;
    endfunction

    function automatic void queue_random_instr(int unsigned max_move);
        tmeu_pkg::op_t op;
        int unsigned   count;
        op = tmeu_pkg::op_t'($urandom_range(7));
        case ($urandom_range(7))
            0:       count = 0;
            1:       count = 255;
            default: count = (op == tmeu_pkg::OP_RIGHT || op == tmeu_pkg::OP_LEFT) ?
                             $urandom_range(max_move, 1) : $urandom_range(255, 1);
        endcase
        queue_instr(op, count, 16'($urandom), 8'($urandom), $urandom_range(3) == 0);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
    endtask

    // Driver: presents queued requests in bursts separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                outcome_queue.push_back(run_instruction(request));
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        // Long stretch with no idle cycles at all.
                        burst_left = 80;
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(24, 1);
                        gap_left   = ($urandom_range(1) == 0) ? 0 : $urandom_range(6, 1);
                    end
                end
            end
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (program_queue.size() != 0)
            begin
                request <= program_queue.pop_front();
                start   <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result must match the oldest prediction.
    always @(posedge clk)
    begin
        tmeu_pkg::result_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (outcome_queue.size() == 0)
                report_mismatch("unexpected result", 32'h0, 32'(result));
            else
            begin
                want = outcome_queue.pop_front();
                if (result.out_valid !== want.out_valid)
                    report_mismatch("out_valid", 32'(want.out_valid),
                                    32'(result.out_valid));
                if (result.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(want.out_byte), 32'(result.out_byte));
                if (result.branch_taken !== want.branch_taken)
                    report_mismatch("branch_taken", 32'(want.branch_taken),
                                    32'(result.branch_taken));
                if (result.program_step !== want.program_step)
                    report_mismatch("program_step", 32'(unsigned'(want.program_step)),
                                    32'(unsigned'(result.program_step)));
                if (result.head_fault !== want.head_fault)
                    report_mismatch("head_fault", 32'(want.head_fault),
                                    32'(result.head_fault));
            end
        end
    end

    // The cycle limit also has to cover the tape clear after reset.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tape_machine_execute_unit_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned n_directed;
        int unsigned excursion_at;
        bit          excursion_done;
        int unsigned kind;
        int unsigned n;

        foreach (model_tape[i])
            model_tape[i] = '0;
        model_head     = 0;
        gen_head       = 0;
        excursion_done = 1'b0;

        // Directed program: fresh tape, wrap of the cell, both brackets both
        // ways, end of input, zero counts and a fault at the left end.
        queue_instr(tmeu_pkg::OP_OUT, 1, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_JZ, 1, 16'h8000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_JNZ, 1, 16'h7FFF, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_LEFT, 1, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_LEFT, 0, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_ADD, 255, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_ADD, 0, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_ADD, 1, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_SUB, 1, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_OUT, 1, 16'hFFFF, 8'hFF, 1'b1);
        queue_instr(tmeu_pkg::OP_JNZ, 1, 16'h7FFF, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_JZ, 1, 16'hFFFB, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_SUB, 255, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_SUB, 0, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_IN, 1, 16'h0000, 8'hA5, 1'b0);
        queue_instr(tmeu_pkg::OP_OUT, 1, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_IN, 1, 16'h0000, 8'h5A, 1'b1);
        queue_instr(tmeu_pkg::OP_OUT, 1, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_IN, 1, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_RIGHT, 255, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_RIGHT, 0, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_IN, 1, 16'h0000, 8'hFF, 1'b0);
        queue_instr(tmeu_pkg::OP_LEFT, 255, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_OUT, 1, 16'h0000, 8'h00, 1'b0);
        queue_instr(tmeu_pkg::OP_LEFT, 255, 16'h0000, 8'h00, 1'b0);
        n_directed = program_queue.size();

        excursion_at = n_directed + $urandom_range(700, 200);
        while (program_queue.size() < n_directed + N_RANDOM)
        begin
            kind = $urandom_range(99);
            if (!excursion_done && program_queue.size() > excursion_at)
            begin
                // Walk to the right end, probe the boundary, then walk back.
                excursion_done = 1'b1;
                while (gen_head + 255 < TAPE_CELLS)
                begin
                    if ($urandom_range(5) == 0)
                        queue_random_instr(8);
                    else
                        queue_instr(tmeu_pkg::OP_RIGHT, 255, 16'($urandom), 8'($urandom),
                                    1'b0);
                end
                if (gen_head != TAPE_CELLS - 1)
                    queue_instr(tmeu_pkg::OP_RIGHT, TAPE_CELLS - 1 - gen_head, 16'h0, 8'h0,
                                1'b0);
                queue_instr(tmeu_pkg::OP_RIGHT, 1, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_RIGHT, 0, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_ADD, $urandom_range(255, 1), 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_OUT, 1, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_RIGHT, $urandom_range(255, 1), 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_LEFT, 1, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_RIGHT, 1, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_RIGHT, 255, 16'h0, 8'h0, 1'b0);
                while (gen_head >= 255)
                begin
                    if ($urandom_range(5) == 0)
                        queue_random_instr(8);
                    else
                        queue_instr(tmeu_pkg::OP_LEFT, 255, 16'($urandom), 8'($urandom),
                                    1'b0);
                end
                queue_instr(tmeu_pkg::OP_LEFT, gen_head + 1, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_LEFT, gen_head, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_OUT, 1, 16'h0, 8'h0, 1'b0);
            end
            else if (kind < 55)
            begin
                repeat ($urandom_range(16, 4))
                    queue_random_instr(8);
            end
            else if (kind < 85)
            begin
                // Countdown loop body: load n, then output and decrement to zero.
                n = $urandom_range(6, 1);
                queue_instr(tmeu_pkg::OP_IN, 1, 16'h0, 8'(n), 1'b0);
                repeat (n)
                begin
                    queue_instr(tmeu_pkg::OP_OUT, 1, 16'h0, 8'h0, 1'b0);
                    queue_instr(tmeu_pkg::OP_SUB, 1, 16'h0, 8'h0, 1'b0);
                    queue_instr(tmeu_pkg::OP_JNZ, 1, 16'($urandom), 8'h0, 1'b0);
                end
                queue_instr(tmeu_pkg::OP_JZ, 1, 16'($urandom), 8'h0, 1'b0);
            end
            else
            begin
                n = $urandom_range(40, 1);
                queue_instr(tmeu_pkg::OP_RIGHT, n, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_ADD, $urandom_range(255, 1), 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_OUT, 1, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_LEFT, n, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_OUT, 1, 16'h0, 8'h0, 1'b0);
                queue_instr(tmeu_pkg::OP_JNZ, 1, 16'($urandom), 8'h0, 1'b0);
            end
        end
        n_total = program_queue.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Every request produces exactly one result.
        while (n_results < n_total)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && outcome_queue.size() == 0 && n_results == n_total)
            $display("tape_machine_execute_unit_tb: PASS");
        else
            $display("tape_machine_execute_unit_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tmeu_pkg.sv
rtl/tmeu_front.sv
rtl/tmeu_queue.sv
rtl/tmeu_back.sv
rtl/tape_machine_execute_unit.sv
rtl/tmeu_checker.sv
verif/tape_machine_execute_unit_tb.sv
